// ===== src/x86fef_pkg.sv =====
// ----------------------------------------------------------------------------
// x86fef_pkg
// Shared types and constants of the function-end finder: walker phases,
// result status codes, opcode values and the step interface structs.
// ----------------------------------------------------------------------------
package x86fef_pkg;

   typedef enum logic [1:0] {
      PH_OPCODE       = 2'd0,
      PH_AFTER_PREFIX = 2'd1,
      PH_MODRM        = 2'd2,
      PH_SKIP         = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_RET = 2'd0,
      STATUS_END = 2'd1,
      STATUS_BAD = 2'd2
   } status_type;

   localparam logic [7:0] OP_PREFIX_66 = 8'h66;
   localparam logic [7:0] OP_RET       = 8'hC3;
   localparam logic [7:0] OP_ADD       = 8'h03;
   localparam logic [7:0] OP_XCHG      = 8'h86;
   localparam logic [7:0] OP_ALU_IMM8  = 8'h83;
   localparam logic [7:0] OP_IMUL_IMM8 = 8'h6B;
   localparam logic [7:0] OP_IMUL_IMM  = 8'h69;
   localparam logic [7:0] OP_MOV_RM8   = 8'h8A;
   localparam logic [7:0] OP_MOV_RM    = 8'h8B;
   localparam logic [7:0] OP_STOS8     = 8'hAA;
   localparam logic [7:0] OP_STOS      = 8'hAB;

   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_REGISTER = 2'd3;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] skip_left;
      logic       wide_prefix_seen;
      logic       memory_mov_flag;
   } walk_state_type;

   typedef struct packed {
      logic       emit;
      status_type status;
      logic [7:0] bad_opcode;
   } step_result_type;

endpackage

// ===== src/x86fef_decode.sv =====
// ----------------------------------------------------------------------------
// x86fef_decode
// One decode step of the instruction walker: from the current walker state
// and one code byte, the next state and whether a function ends here.
// ----------------------------------------------------------------------------
module x86fef_decode (
   input  x86fef_pkg::walk_state_type  state_cur,
   input  logic [7:0]                  code_byte,
   input  logic                        buffer_end,
   output x86fef_pkg::walk_state_type  state_next,
   output x86fef_pkg::step_result_type result
);

   logic [2:0] imm_bytes;
   logic [2:0] skip_count;
   logic       skip_start;
   logic [2:0] skip_dec;
   logic [1:0] mod_field;

   assign imm_bytes = state_cur.wide_prefix_seen ? 3'd2 : 3'd4;
   assign mod_field = code_byte[7:6];

   always_comb begin
      state_next        = state_cur;
      result.emit       = 1'b0;
      result.status     = x86fef_pkg::STATUS_END;
      result.bad_opcode = 8'h00;
      skip_start        = 1'b0;
      skip_count        = 3'd0;
      skip_dec          = 3'd0;

      case (state_cur.phase)
         x86fef_pkg::PH_OPCODE, x86fef_pkg::PH_AFTER_PREFIX: begin
            if (state_cur.phase == x86fef_pkg::PH_OPCODE
                && code_byte == x86fef_pkg::OP_PREFIX_66) begin
               state_next.wide_prefix_seen = 1'b1;
               state_next.phase            = x86fef_pkg::PH_AFTER_PREFIX;
            end else begin
               case (code_byte) inside
                  [8'h40:8'h4F],
                  x86fef_pkg::OP_STOS8, x86fef_pkg::OP_STOS: begin
                     skip_start = 1'b1;
                     skip_count = 3'd0;
                  end
                  [8'hB0:8'hB7],
                  x86fef_pkg::OP_ADD, x86fef_pkg::OP_XCHG: begin
                     skip_start = 1'b1;
                     skip_count = 3'd1;
                  end
                  [8'hB8:8'hBF]: begin
                     skip_start = 1'b1;
                     skip_count = imm_bytes;
                  end
                  x86fef_pkg::OP_ALU_IMM8, x86fef_pkg::OP_IMUL_IMM8: begin
                     skip_start = 1'b1;
                     skip_count = 3'd2;
                  end
                  x86fef_pkg::OP_IMUL_IMM: begin
                     skip_start = 1'b1;
                     skip_count = imm_bytes + 3'd1;
                  end
                  x86fef_pkg::OP_MOV_RM8, x86fef_pkg::OP_MOV_RM: begin
                     state_next.phase = x86fef_pkg::PH_MODRM;
                  end
                  x86fef_pkg::OP_RET: begin
                     result.emit   = 1'b1;
                     result.status = x86fef_pkg::STATUS_RET;
                  end
                  default: begin
                     result.emit       = 1'b1;
                     result.status     = x86fef_pkg::STATUS_BAD;
                     result.bad_opcode = code_byte;
                  end
               endcase
            end
         end
         x86fef_pkg::PH_MODRM: begin
            if (mod_field != x86fef_pkg::MOD_REGISTER) begin
               state_next.memory_mov_flag = 1'b1;
            end
            skip_start = 1'b1;
            skip_count = (mod_field == x86fef_pkg::MOD_DISP8) ? 3'd1 : 3'd0;
         end
         default: begin
            skip_dec = (state_cur.skip_left != 3'd0) ? state_cur.skip_left - 3'd1
                                                     : 3'd0;
            state_next.skip_left = skip_dec;
            if (skip_dec == 3'd0) begin
               state_next.phase            = x86fef_pkg::PH_OPCODE;
               state_next.wide_prefix_seen = 1'b0;
            end
         end
      endcase

      if (skip_start) begin
         if (skip_count == 3'd0) begin
            state_next.phase            = x86fef_pkg::PH_OPCODE;
            state_next.wide_prefix_seen = 1'b0;
         end else begin
            state_next.phase     = x86fef_pkg::PH_SKIP;
            state_next.skip_left = skip_count;
         end
      end

      if (!result.emit && buffer_end) begin
         result.emit   = 1'b1;
         result.status = x86fef_pkg::STATUS_END;
      end
   end

endmodule

// ===== src/x86_subset_function_end_finder.sv =====
// ----------------------------------------------------------------------------
// x86_subset_function_end_finder
// Walks a code byte stream as a small x86 subset and reports each function.
// ----------------------------------------------------------------------------
// One code byte is taken per transaction and a new byte can be taken every
// cycle while req_stall is low. A result, when the byte ends a function (ret,
// an opcode outside the subset, or the last byte of the buffer), appears on
// the rsp_ channel in the cycle after that byte is accepted; a single result
// register holds it, and req_stall rises only while that register is full
// and rsp_stall is high. The function length counter is LENGTH_BITS wide,
// saturates at its maximum and is reported in its low 16 bits.
module x86_subset_function_end_finder #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_length,
   output logic        rsp_reads_source_memory,
   output logic [7:0]  rsp_bad_opcode
);

   localparam int WideBits = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
   localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};

   x86fef_pkg::walk_state_type  state_ff, state_in, state_step;
   x86fef_pkg::step_result_type step_result;
   logic [LENGTH_BITS-1:0]      count_ff, count_in, count_step;
   logic [WideBits-1:0]         count_wide;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff, status_in;
   logic [15:0]                 length_ff, length_in;
   logic                        memory_ff, memory_in;
   logic [7:0]                  bad_ff, bad_in;

   logic                        accept;
   logic                        fire;

   x86fef_decode u_decode (
      .state_cur  (state_ff),
      .code_byte  (req_code_byte),
      .buffer_end (req_buffer_end),
      .state_next (state_step),
      .result     (step_result)
   );

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;
   assign fire       = accept && step_result.emit;
   assign count_step = (count_ff != CountMax) ? count_ff + 1'b1 : count_ff;
   assign count_wide = WideBits'(count_step);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      length_in    = length_ff;
      memory_in    = memory_ff;
      bad_in       = bad_ff;
      if (accept) begin
         if (step_result.emit) begin
            state_in.phase            = x86fef_pkg::PH_OPCODE;
            state_in.skip_left        = 3'd0;
            state_in.wide_prefix_seen = 1'b0;
            state_in.memory_mov_flag  = 1'b0;
            count_in                  = '0;
         end else begin
            state_in = state_step;
            count_in = count_step;
         end
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         status_in    = step_result.status;
         length_in    = count_wide[15:0];
         memory_in    = state_step.memory_mov_flag;
         bad_in       = step_result.bad_opcode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase            <= x86fef_pkg::PH_OPCODE;
         state_ff.skip_left        <= 3'd0;
         state_ff.wide_prefix_seen <= 1'b0;
         state_ff.memory_mov_flag  <= 1'b0;
         count_ff                  <= '0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      length_ff <= length_in;
      memory_ff <= memory_in;
      bad_ff    <= bad_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_length              = length_ff;
   assign rsp_reads_source_memory = memory_ff;
   assign rsp_bad_opcode          = bad_ff;

endmodule

// ===== src/x86fef_checker.sv =====
// ----------------------------------------------------------------------------
// x86fef_checker
// Port-level checks of the function-end finder, bound to the top level.
// ----------------------------------------------------------------------------
module x86fef_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_buffer_end,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_length,
   input logic [7:0]  rsp_bad_opcode
);

   property p_end_gives_result;
      @(posedge clock) disable iff (reset)
         (req_valid && !req_stall && req_buffer_end) |=> rsp_valid;
   endproperty
   a_end_gives_result: assert property (p_end_gives_result)
      else $error("last buffer byte accepted without a result");

   property p_status_code;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_status == x86fef_pkg::STATUS_RET
                        || rsp_status == x86fef_pkg::STATUS_END
                        || rsp_status == x86fef_pkg::STATUS_BAD);
   endproperty
   a_status_code: assert property (p_status_code)
      else $error("result status outside the defined codes");

   property p_bad_only_on_error;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_status != x86fef_pkg::STATUS_BAD) |-> rsp_bad_opcode == 8'h00;
   endproperty
   a_bad_only_on_error: assert property (p_bad_only_on_error)
      else $error("bad opcode reported without an error status");

   property p_stalled_holds;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_length));
   endproperty
   a_stalled_holds: assert property (p_stalled_holds)
      else $error("stalled result transaction changed");

endmodule

bind x86_subset_function_end_finder x86fef_checker u_x86fef_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_buffer_end (req_buffer_end),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_length     (rsp_length),
   .rsp_bad_opcode (rsp_bad_opcode)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the x86 subset function-end finder. A table of
// directed byte sequences covers ret, double prefix, bad opcodes and a buffer
// that ends mid-instruction. Random functions built from the opcode subset
// follow, mixed with corrupted bytes and early buffer ends. Every accepted
// byte runs through a byte-level walker model, and each rsp_ transaction is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int LENGTH_BITS      = 16;
   localparam int RANDOM_ITEMS     = 710;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int TAIL_CYCLES      = 8;
   localparam int WATCHDOG_LIMIT   = 1000;

   localparam logic [7:0] OP_INC_BASE      = 8'h40;
   localparam logic [7:0] OP_MOV_IMM8_BASE = 8'hB0;
   localparam logic [7:0] OP_MOV_IMM_BASE  = 8'hB8;

   typedef struct packed {
      x86fef_pkg::status_type status;
      logic [15:0]            byte_len;
      logic                   reads_memory;
      logic [7:0]             bad_opcode;
   } finding_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } code_item_type;

   typedef struct packed {
      logic [7:0]  code;
      logic        last;
      bit          typed;
      finding_type result;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [26] = '{
      '{x86fef_pkg::OP_RET,       1'b0, 1'b1,
        '{x86fef_pkg::STATUS_RET, 16'd1, 1'b0, 8'h00}},
      '{x86fef_pkg::OP_PREFIX_66, 1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_PREFIX_66, 1'b0, 1'b1,
        '{x86fef_pkg::STATUS_BAD, 16'd2, 1'b0, x86fef_pkg::OP_PREFIX_66}},
      '{8'h00,                    1'b0, 1'b1,
        '{x86fef_pkg::STATUS_BAD, 16'd1, 1'b0, 8'h00}},
      '{8'hFF,                    1'b1, 1'b1,
        '{x86fef_pkg::STATUS_BAD, 16'd1, 1'b0, 8'hFF}},
      '{x86fef_pkg::OP_MOV_RM,    1'b0, 1'b0, '0},
      '{8'h45,                    1'b0, 1'b0, '0},
      '{8'h10,                    1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_RET,       1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_PREFIX_66, 1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_IMUL_IMM,  1'b0, 1'b0, '0},
      '{8'hC0,                    1'b0, 1'b0, '0},
      '{8'h01,                    1'b0, 1'b0, '0},
      '{8'h02,                    1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_RET,       1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_PREFIX_66, 1'b0, 1'b0, '0},
      '{OP_MOV_IMM_BASE,          1'b0, 1'b0, '0},
      '{8'h34,                    1'b0, 1'b0, '0},
      '{8'h12,                    1'b0, 1'b0, '0},
      '{OP_INC_BASE | 8'h0F,      1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_STOS,      1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_RET,       1'b1, 1'b0, '0},
      '{x86fef_pkg::OP_MOV_RM8,   1'b0, 1'b0, '0},
      '{8'hC0,                    1'b0, 1'b0, '0},
      '{x86fef_pkg::OP_ALU_IMM8,  1'b0, 1'b0, '0},
      '{8'hFF,                    1'b1, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_code_byte;
   logic        req_buffer_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_length;
   logic        rsp_reads_source_memory;
   logic [7:0]  rsp_bad_opcode;

   x86fef_pkg::phase_type  walk_phase    = x86fef_pkg::PH_OPCODE;
   logic [2:0]             skip_count    = 3'd0;
   logic                   wide_prefix   = 1'b0;
   logic [LENGTH_BITS-1:0] fn_length     = '0;
   logic                   mem_read_seen = 1'b0;

   finding_type expected_findings [$];
   int idle_level;
   int holds_requested;
   int holds_served;
   int mismatches;
   int bytes_sent;
   int random_bytes;
   int ret_count;
   int end_count;
   int bad_count;
   int quiet_cycles;

   x86_subset_function_end_finder #(
      .LENGTH_BITS(LENGTH_BITS)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_code_byte           (req_code_byte),
      .req_buffer_end          (req_buffer_end),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_status              (rsp_status),
      .rsp_length              (rsp_length),
      .rsp_reads_source_memory (rsp_reads_source_memory),
      .rsp_bad_opcode          (rsp_bad_opcode)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void start_operands(input logic [2:0] count);
      if (count == 3'd0) begin
         walk_phase  = x86fef_pkg::PH_OPCODE;
         wide_prefix = 1'b0;
      end else begin
         walk_phase = x86fef_pkg::PH_SKIP;
         skip_count = count;
      end
   endfunction

   function automatic bit walk_byte(input logic [7:0] code, input logic last,
                                    output finding_type found);
      logic [2:0]             imm_bytes;
      logic [2:0]             operand_bytes;
      logic [1:0]             mod;
      bit                     known;
      bit                     done;
      x86fef_pkg::status_type status;
      logic [7:0]             bad;
      imm_bytes     = wide_prefix ? 3'd2 : 3'd4;
      operand_bytes = 3'd0;
      known         = 1'b1;
      done          = 1'b0;
      status        = x86fef_pkg::STATUS_END;
      bad           = 8'h00;
      found         = '0;
      if (fn_length != '1)
         fn_length = fn_length + 1'b1;
      case (walk_phase)
         x86fef_pkg::PH_OPCODE, x86fef_pkg::PH_AFTER_PREFIX: begin
            if (walk_phase == x86fef_pkg::PH_OPCODE && code == x86fef_pkg::OP_PREFIX_66) begin
               wide_prefix = 1'b1;
               walk_phase  = x86fef_pkg::PH_AFTER_PREFIX;
            end else if (code == x86fef_pkg::OP_MOV_RM8 || code == x86fef_pkg::OP_MOV_RM) begin
               walk_phase = x86fef_pkg::PH_MODRM;
            end else if (code == x86fef_pkg::OP_RET) begin
               done   = 1'b1;
               status = x86fef_pkg::STATUS_RET;
            end else begin
               if (code[7:4] == OP_INC_BASE[7:4])
                  operand_bytes = 3'd0;
               else if (code[7:3] == OP_MOV_IMM8_BASE[7:3])
                  operand_bytes = 3'd1;
               else if (code[7:3] == OP_MOV_IMM_BASE[7:3])
                  operand_bytes = imm_bytes;
               else if (code == x86fef_pkg::OP_ADD || code == x86fef_pkg::OP_XCHG)
                  operand_bytes = 3'd1;
               else if (code == x86fef_pkg::OP_ALU_IMM8 || code == x86fef_pkg::OP_IMUL_IMM8)
                  operand_bytes = 3'd2;
               else if (code == x86fef_pkg::OP_IMUL_IMM)
                  operand_bytes = imm_bytes + 3'd1;
               else if (code == x86fef_pkg::OP_STOS8 || code == x86fef_pkg::OP_STOS)
                  operand_bytes = 3'd0;
               else
                  known = 1'b0;
               if (known) begin
                  start_operands(operand_bytes);
               end else begin
                  done   = 1'b1;
                  status = x86fef_pkg::STATUS_BAD;
                  bad    = code;
               end
            end
         end
         x86fef_pkg::PH_MODRM: begin
            mod = code[7:6];
            if (mod != x86fef_pkg::MOD_REGISTER)
               mem_read_seen = 1'b1;
            start_operands(mod == x86fef_pkg::MOD_DISP8 ? 3'd1 : 3'd0);
         end
         default: begin
            if (skip_count != 3'd0)
               skip_count = skip_count - 3'd1;
            if (skip_count == 3'd0) begin
               walk_phase  = x86fef_pkg::PH_OPCODE;
               wide_prefix = 1'b0;
            end
         end
      endcase
      if (last)
         done = 1'b1;
      if (done) begin
         found.status       = status;
         found.byte_len     = fn_length[15:0];
         found.reads_memory = mem_read_seen;
         found.bad_opcode   = bad;
         walk_phase         = x86fef_pkg::PH_OPCODE;
         skip_count         = 3'd0;
         wide_prefix        = 1'b0;
         fn_length          = '0;
         mem_read_seen      = 1'b0;
      end
      return done;
   endfunction

   task automatic send_item(input logic [7:0] code, input logic last, input bit gap_ok,
                            input bit typed, input finding_type typed_result);
      int          gap;
      bit          emitted;
      finding_type predicted;
      if (gap_ok && idle_level != 0 && $urandom_range(0, 99) < idle_level * 15) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_code_byte  <= code;
      req_buffer_end <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
      emitted = walk_byte(code, last, predicted);
      if (typed)
         expected_findings.push_back(typed_result);
      else if (emitted)
         expected_findings.push_back(predicted);
   endtask

   task automatic wait_for_findings();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_findings.size() != 0);
   endtask

   initial begin : stimulus
      int            n_instr;
      int            extra;
      int            next_mode_change;
      bit            wide;
      logic [7:0]    opcode;
      logic [7:0]    modrm;
      code_item_type fn_bytes [$];
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_code_byte  <= 8'h00;
      req_buffer_end <= 1'b0;
      idle_level = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].last, 1'b1,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      wait_for_findings();

      // hold the result side off while rets keep coming
      holds_requested++;
      repeat (12)
         send_item(x86fef_pkg::OP_RET, 1'b0, 1'b0, 1'b1,
                   '{x86fef_pkg::STATUS_RET, 16'd1, 1'b0, 8'h00});
      wait_for_findings();

      next_mode_change = 0;
      while (random_bytes < RANDOM_ITEMS) begin
         if (random_bytes >= next_mode_change) begin
            idle_level = $urandom_range(0, 2);
            next_mode_change += 100;
         end
         fn_bytes.delete();
         n_instr = $urandom_range(0, 6);
         repeat (n_instr) begin
            wide  = ($urandom_range(0, 3) == 0);
            extra = 0;
            if (wide)
               fn_bytes.push_back('{x86fef_pkg::OP_PREFIX_66, 1'b0});
            case ($urandom_range(0, 11))
               0: opcode = OP_INC_BASE | 8'($urandom_range(0, 15));
               1: begin
                  opcode = OP_MOV_IMM8_BASE | 8'($urandom_range(0, 7));
                  extra  = 1;
               end
               2: begin
                  opcode = OP_MOV_IMM_BASE | 8'($urandom_range(0, 7));
                  extra  = wide ? 2 : 4;
               end
               3: begin
                  opcode = x86fef_pkg::OP_ADD;
                  extra  = 1;
               end
               4: begin
                  opcode = x86fef_pkg::OP_XCHG;
                  extra  = 1;
               end
               5: begin
                  opcode = x86fef_pkg::OP_ALU_IMM8;
                  extra  = 2;
               end
               6: begin
                  opcode = x86fef_pkg::OP_IMUL_IMM8;
                  extra  = 2;
               end
               7: begin
                  opcode = x86fef_pkg::OP_IMUL_IMM;
                  extra  = wide ? 3 : 5;
               end
               8, 9: opcode = $urandom_range(0, 1) ? x86fef_pkg::OP_MOV_RM
                                                   : x86fef_pkg::OP_MOV_RM8;
               10: opcode = $urandom_range(0, 1) ? x86fef_pkg::OP_STOS
                                                 : x86fef_pkg::OP_STOS8;
               default: opcode = 8'($urandom);
            endcase
            fn_bytes.push_back('{opcode, 1'b0});
            if (opcode == x86fef_pkg::OP_MOV_RM || opcode == x86fef_pkg::OP_MOV_RM8) begin
               modrm = 8'($urandom);
               fn_bytes.push_back('{modrm, 1'b0});
               if (modrm[7:6] == x86fef_pkg::MOD_DISP8)
                  extra = 1;
            end
            repeat (extra)
               fn_bytes.push_back('{8'($urandom), 1'b0});
         end
         case ($urandom_range(0, 9))
            7: fn_bytes.push_back('{8'($urandom), 1'b0});
            8, 9: begin
               if (fn_bytes.size() == 0)
                  fn_bytes.push_back('{8'($urandom), 1'b0});
               fn_bytes[fn_bytes.size() - 1].last = 1'b1;
            end
            default: fn_bytes.push_back('{x86fef_pkg::OP_RET, 1'b0});
         endcase
         // corrupt a few bytes and cut a few buffers short
         foreach (fn_bytes[k]) begin
            if ($urandom_range(0, 99) < 2)
               fn_bytes[k].code = 8'($urandom);
            if ($urandom_range(0, 99) < 2)
               fn_bytes[k].last = 1'b1;
         end
         foreach (fn_bytes[k])
            send_item(fn_bytes[k].code, fn_bytes[k].last, 1'b1, 1'b0, '0);
         random_bytes += fn_bytes.size();
      end

      wait_for_findings();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d code bytes: directed rows, a ret burst under back-pressure",
               bytes_sent);
      $display("and %0d random bytes; %0d ret, %0d end, %0d bad.",
               random_bytes, ret_count, end_count, bad_count);
      if (mismatches == 0 && expected_findings.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : receiver
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_requested) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_level != 0 && $urandom_range(0, 99) < idle_level * 12) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      finding_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_status == x86fef_pkg::STATUS_RET)
            ret_count++;
         else if (rsp_status == x86fef_pkg::STATUS_END)
            end_count++;
         else
            bad_count++;
         if (expected_findings.size() == 0) begin
            $display("%0t: unexpected result, status %0d length %0d", $time, rsp_status,
                     rsp_length);
            mismatches++;
         end else begin
            want = expected_findings.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
               mismatches++;
            end
            if (rsp_length !== want.byte_len) begin
               $display("%0t: length expected %0d, got %0d", $time, want.byte_len, rsp_length);
               mismatches++;
            end
            if (rsp_reads_source_memory !== want.reads_memory) begin
               $display("%0t: reads_source_memory expected %0b, got %0b", $time,
                        want.reads_memory, rsp_reads_source_memory);
               mismatches++;
            end
            if (rsp_bad_opcode !== want.bad_opcode) begin
               $display("%0t: bad_opcode expected %02h, got %02h", $time, want.bad_opcode,
                        rsp_bad_opcode);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                  WATCHDOG_LIMIT, expected_findings.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
